@@ design/rhwpf_pkg.sv @@
// ----------------------------------------------------------------------------
// rhwpf_pkg
// Shared types, widths and register codes for the RGB/HSV window point filter.
// ----------------------------------------------------------------------------
package rhwpf_pkg;

   localparam int FRAC_BITS_DEF = 6;

   localparam int COORD_W    = 16;
   localparam int CHAN_W     = 8;
   localparam int HUE_CFG_W  = 9;
   localparam int HUE_Q_W    = 15;
   localparam int SAT_Q_W    = 13;
   localparam int HUE_NUM_W  = 17;
   localparam int SAT_NUM_W  = 15;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_HUE_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HUE_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SAT_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SAT_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VAL_MIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_VAL_MAX = 3'd5;

   localparam logic [HUE_CFG_W-1:0] HUE_MIN_RST = 9'd0;
   localparam logic [HUE_CFG_W-1:0] HUE_MAX_RST = 9'd62;
   localparam logic [CHAN_W-1:0]    SAT_MIN_RST = 8'd0;
   localparam logic [CHAN_W-1:0]    SAT_MAX_RST = 8'd255;
   localparam logic [CHAN_W-1:0]    VAL_MIN_RST = 8'd235;
   localparam logic [CHAN_W-1:0]    VAL_MAX_RST = 8'd255;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x_mm;
      logic signed [COORD_W-1:0] pos_y_mm;
      logic signed [COORD_W-1:0] pos_z_mm;
      logic [CHAN_W-1:0]         red;
      logic [CHAN_W-1:0]         green;
      logic [CHAN_W-1:0]         blue;
   } point_type;

   typedef struct packed {
      logic [HUE_CFG_W-1:0] hue_min_deg;
      logic [HUE_CFG_W-1:0] hue_max_deg;
      logic [CHAN_W-1:0]    sat_min_pct;
      logic [CHAN_W-1:0]    sat_max_pct;
      logic [CHAN_W-1:0]    val_min;
      logic [CHAN_W-1:0]    val_max;
   } window_cfg_type;

endpackage

@@ design/rgb_hsv_window_point_filter_core.sv @@
// Throughput: one transaction per cycle while rsp_ready does not stall the output;
//   the divider chain of FRAC_BITS + 17 one-bit restoring stages sets the depth,
//   and every stage holds one point.
// Reset: synchronous, active high; clears all valid bits and loads the window
//   registers with their defaults. No clearing pass.
// ----------------------------------------------------------------------------
// rgb_hsv_window_point_filter_core
// Converts each point's colour to HSV and passes the point on only when hue,
// saturation and brightness fall inside the configured windows.
// ----------------------------------------------------------------------------
module rgb_hsv_window_point_filter_core import rhwpf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_pos_x_mm,
   input  logic signed [COORD_W-1:0] req_pos_y_mm,
   input  logic signed [COORD_W-1:0] req_pos_z_mm,
   input  logic [CHAN_W-1:0]         req_red,
   input  logic [CHAN_W-1:0]         req_green,
   input  logic [CHAN_W-1:0]         req_blue,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_out_x_mm,
   output logic signed [COORD_W-1:0] rsp_out_y_mm,
   output logic signed [COORD_W-1:0] rsp_out_z_mm,
   output logic [CHAN_W-1:0]         rsp_out_red,
   output logic [CHAN_W-1:0]         rsp_out_green,
   output logic [CHAN_W-1:0]         rsp_out_blue,
   output logic [HUE_Q_W-1:0]        rsp_hue_q6,
   output logic [SAT_Q_W-1:0]        rsp_sat_q6,
   output logic [CHAN_W-1:0]         rsp_brightness,

   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]     csr_prdata,
   output logic                      csr_pready
);

   localparam int NUM_W = HUE_NUM_W + FRAC_BITS;

   window_cfg_type cfg_ff;
   logic           csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;

   point_type         req_point, rsp_point;

   logic              chain_valid [NUM_W+1];
   logic              chain_ready [NUM_W+1];
   point_type         chain_point [NUM_W+1];
   logic              chain_grey  [NUM_W+1];
   logic [NUM_W-1:0]  chain_hue_word [NUM_W+1];
   logic [CHAN_W-1:0] chain_hue_rem  [NUM_W+1];
   logic [CHAN_W-1:0] chain_hue_div  [NUM_W+1];
   logic [NUM_W-1:0]  chain_sat_word [NUM_W+1];
   logic [CHAN_W-1:0] chain_sat_rem  [NUM_W+1];
   logic [CHAN_W-1:0] chain_sat_div  [NUM_W+1];

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_IDX_W+1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue_min_deg <= HUE_MIN_RST;
         cfg_ff.hue_max_deg <= HUE_MAX_RST;
         cfg_ff.sat_min_pct <= SAT_MIN_RST;
         cfg_ff.sat_max_pct <= SAT_MAX_RST;
         cfg_ff.val_min     <= VAL_MIN_RST;
         cfg_ff.val_max     <= VAL_MAX_RST;
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_HUE_MIN: cfg_ff.hue_min_deg <= csr_pwdata[HUE_CFG_W-1:0];
            REG_HUE_MAX: cfg_ff.hue_max_deg <= csr_pwdata[HUE_CFG_W-1:0];
            REG_SAT_MIN: cfg_ff.sat_min_pct <= csr_pwdata[CHAN_W-1:0];
            REG_SAT_MAX: cfg_ff.sat_max_pct <= csr_pwdata[CHAN_W-1:0];
            REG_VAL_MIN: cfg_ff.val_min     <= csr_pwdata[CHAN_W-1:0];
            REG_VAL_MAX: cfg_ff.val_max     <= csr_pwdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_HUE_MIN: csr_prdata = CSR_DATA_W'(cfg_ff.hue_min_deg);
         REG_HUE_MAX: csr_prdata = CSR_DATA_W'(cfg_ff.hue_max_deg);
         REG_SAT_MIN: csr_prdata = CSR_DATA_W'(cfg_ff.sat_min_pct);
         REG_SAT_MAX: csr_prdata = CSR_DATA_W'(cfg_ff.sat_max_pct);
         REG_VAL_MIN: csr_prdata = CSR_DATA_W'(cfg_ff.val_min);
         REG_VAL_MAX: csr_prdata = CSR_DATA_W'(cfg_ff.val_max);
         default:     csr_prdata = '0;
      endcase
   end

   assign req_point.pos_x_mm = req_pos_x_mm;
   assign req_point.pos_y_mm = req_pos_y_mm;
   assign req_point.pos_z_mm = req_pos_z_mm;
   assign req_point.red      = req_red;
   assign req_point.green    = req_green;
   assign req_point.blue     = req_blue;

   rhwpf_front #(
      .FRAC_BITS (FRAC_BITS),
      .NUM_W     (NUM_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_point     (req_point),
      .out_valid    (chain_valid[0]),
      .out_ready    (chain_ready[0]),
      .out_point    (chain_point[0]),
      .out_grey     (chain_grey[0]),
      .out_hue_word (chain_hue_word[0]),
      .out_hue_div  (chain_hue_div[0]),
      .out_sat_word (chain_sat_word[0]),
      .out_sat_div  (chain_sat_div[0])
   );

   assign chain_hue_rem[0] = '0;
   assign chain_sat_rem[0] = '0;

   for (genvar i = 0; i < NUM_W; i++) begin : g_div
      rhwpf_div_stage #(
         .NUM_W (NUM_W)
      ) u_stage (
         .clock        (clock),
         .reset        (reset),
         .in_valid     (chain_valid[i]),
         .in_ready     (chain_ready[i]),
         .in_point     (chain_point[i]),
         .in_grey      (chain_grey[i]),
         .in_hue_word  (chain_hue_word[i]),
         .in_hue_rem   (chain_hue_rem[i]),
         .in_hue_div   (chain_hue_div[i]),
         .in_sat_word  (chain_sat_word[i]),
         .in_sat_rem   (chain_sat_rem[i]),
         .in_sat_div   (chain_sat_div[i]),
         .out_valid    (chain_valid[i+1]),
         .out_ready    (chain_ready[i+1]),
         .out_point    (chain_point[i+1]),
         .out_grey     (chain_grey[i+1]),
         .out_hue_word (chain_hue_word[i+1]),
         .out_hue_rem  (chain_hue_rem[i+1]),
         .out_hue_div  (chain_hue_div[i+1]),
         .out_sat_word (chain_sat_word[i+1]),
         .out_sat_rem  (chain_sat_rem[i+1]),
         .out_sat_div  (chain_sat_div[i+1])
      );
   end

   rhwpf_window #(
      .FRAC_BITS (FRAC_BITS),
      .NUM_W     (NUM_W)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (chain_valid[NUM_W]),
      .in_ready   (chain_ready[NUM_W]),
      .in_point   (chain_point[NUM_W]),
      .in_grey    (chain_grey[NUM_W]),
      .in_hue_quo (chain_hue_word[NUM_W]),
      .in_sat_quo (chain_sat_word[NUM_W]),
      .in_bright  (chain_sat_div[NUM_W]),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_point  (rsp_point),
      .out_hue_q6 (rsp_hue_q6),
      .out_sat_q6 (rsp_sat_q6),
      .out_bright (rsp_brightness)
   );

   assign rsp_out_x_mm  = rsp_point.pos_x_mm;
   assign rsp_out_y_mm  = rsp_point.pos_y_mm;
   assign rsp_out_z_mm  = rsp_point.pos_z_mm;
   assign rsp_out_red   = rsp_point.red;
   assign rsp_out_green = rsp_point.green;
   assign rsp_out_blue  = rsp_point.blue;

endmodule

@@ design/rhwpf_front.sv @@
// ----------------------------------------------------------------------------
// rhwpf_front
// Two-stage front end: channel max/min and sector, then hue and saturation
// dividends and divisors for the divider chain.
// ----------------------------------------------------------------------------
module rhwpf_front import rhwpf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int NUM_W     = HUE_NUM_W + FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  point_type         in_point,
   output logic              out_valid,
   input  logic              out_ready,
   output point_type         out_point,
   output logic              out_grey,
   output logic [NUM_W-1:0]  out_hue_word,
   output logic [CHAN_W-1:0] out_hue_div,
   output logic [NUM_W-1:0]  out_sat_word,
   output logic [CHAN_W-1:0] out_sat_div
);

   logic              s1_valid_ff, s1_valid_in;
   point_type         s1_point_ff;
   sector_type        s1_sector_ff, s1_sector_in;
   logic [CHAN_W-1:0] s1_max_ff, s1_max_in;
   logic [CHAN_W-1:0] s1_min_in;
   logic [CHAN_W-1:0] s1_diff_ff;
   logic signed [CHAN_W:0] s1_cdiff_ff, s1_cdiff_in;
   logic              s1_grey_ff;
   logic              s1_ready;

   logic              s2_valid_ff, s2_valid_in;
   point_type         s2_point_ff;
   logic              s2_grey_ff;
   logic [NUM_W-1:0]  s2_hue_word_ff, s2_hue_word_in;
   logic [NUM_W-1:0]  s2_sat_word_ff, s2_sat_word_in;
   logic [CHAN_W-1:0] s2_hue_div_ff;
   logic [CHAN_W-1:0] s2_sat_div_ff;
   logic              s2_ready;

   logic signed [18:0]        cdiff_x, d_x, base_term, num_raw, num_wrap;
   logic [SAT_NUM_W-1:0]      sat_prod;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // sector and extremes; ties go red, then green
   always_comb begin
      logic [CHAN_W-1:0] r, g, b;
      r = in_point.red;
      g = in_point.green;
      b = in_point.blue;
      if (r >= g && r >= b) begin
         s1_sector_in = SECTOR_RED;
         s1_max_in    = r;
         s1_cdiff_in  = $signed({1'b0, g}) - $signed({1'b0, b});
      end else if (g >= b) begin
         s1_sector_in = SECTOR_GREEN;
         s1_max_in    = g;
         s1_cdiff_in  = $signed({1'b0, b}) - $signed({1'b0, r});
      end else begin
         s1_sector_in = SECTOR_BLUE;
         s1_max_in    = b;
         s1_cdiff_in  = $signed({1'b0, r}) - $signed({1'b0, g});
      end
      s1_min_in = r;
      if (g < s1_min_in) begin
         s1_min_in = g;
      end
      if (b < s1_min_in) begin
         s1_min_in = b;
      end
   end

   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_point_ff  <= in_point;
         s1_sector_ff <= s1_sector_in;
         s1_max_ff    <= s1_max_in;
         s1_diff_ff   <= s1_max_in - s1_min_in;
         s1_cdiff_ff  <= s1_cdiff_in;
         s1_grey_ff   <= (s1_max_in == s1_min_in);
      end
   end

   // hue dividend 60*diff + offset*d, wrapped into [0, 360*d)
   always_comb begin
      cdiff_x = 19'(s1_cdiff_ff);
      d_x     = $signed({11'd0, s1_diff_ff});
      unique case (s1_sector_ff)
         SECTOR_RED:   base_term = 19'sd0;
         SECTOR_GREEN: base_term = d_x * 19'sd120;
         SECTOR_BLUE:  base_term = d_x * 19'sd240;
         default:      base_term = 19'sd0;
      endcase
      num_raw  = cdiff_x * 19'sd60 + base_term;
      num_wrap = (num_raw < 19'sd0) ? num_raw + d_x * 19'sd360 : num_raw;
      sat_prod = SAT_NUM_W'(s1_diff_ff) * SAT_NUM_W'(100);
   end

   assign s2_hue_word_in = NUM_W'(num_wrap[HUE_NUM_W-1:0]) << FRAC_BITS;
   assign s2_sat_word_in = NUM_W'(sat_prod) << FRAC_BITS;
   assign s2_valid_in    = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_point_ff    <= s1_point_ff;
         s2_grey_ff     <= s1_grey_ff;
         s2_hue_word_ff <= s2_hue_word_in;
         s2_sat_word_ff <= s2_sat_word_in;
         s2_hue_div_ff  <= s1_diff_ff;
         s2_sat_div_ff  <= s1_max_ff;
      end
   end

   assign out_valid    = s2_valid_ff;
   assign out_point    = s2_point_ff;
   assign out_grey     = s2_grey_ff;
   assign out_hue_word = s2_hue_word_ff;
   assign out_hue_div  = s2_hue_div_ff;
   assign out_sat_word = s2_sat_word_ff;
   assign out_sat_div  = s2_sat_div_ff;

endmodule

@@ design/rhwpf_div_stage.sv @@
// ----------------------------------------------------------------------------
// rhwpf_div_stage
// One restoring step of the hue and saturation dividers: one quotient bit
// each, dividend bits shifted out as quotient bits shift in.
// ----------------------------------------------------------------------------
module rhwpf_div_stage import rhwpf_pkg::*; #(
   parameter int NUM_W = HUE_NUM_W + FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  point_type         in_point,
   input  logic              in_grey,
   input  logic [NUM_W-1:0]  in_hue_word,
   input  logic [CHAN_W-1:0] in_hue_rem,
   input  logic [CHAN_W-1:0] in_hue_div,
   input  logic [NUM_W-1:0]  in_sat_word,
   input  logic [CHAN_W-1:0] in_sat_rem,
   input  logic [CHAN_W-1:0] in_sat_div,
   output logic              out_valid,
   input  logic              out_ready,
   output point_type         out_point,
   output logic              out_grey,
   output logic [NUM_W-1:0]  out_hue_word,
   output logic [CHAN_W-1:0] out_hue_rem,
   output logic [CHAN_W-1:0] out_hue_div,
   output logic [NUM_W-1:0]  out_sat_word,
   output logic [CHAN_W-1:0] out_sat_rem,
   output logic [CHAN_W-1:0] out_sat_div
);

   logic              valid_ff, valid_in;
   point_type         point_ff;
   logic              grey_ff;
   logic [NUM_W-1:0]  hue_word_ff, hue_word_in;
   logic [CHAN_W-1:0] hue_rem_ff, hue_rem_in;
   logic [CHAN_W-1:0] hue_div_ff;
   logic [NUM_W-1:0]  sat_word_ff, sat_word_in;
   logic [CHAN_W-1:0] sat_rem_ff, sat_rem_in;
   logic [CHAN_W-1:0] sat_div_ff;

   logic [CHAN_W:0]   hue_trial, sat_trial;
   logic              hue_take, sat_take;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      hue_trial   = {in_hue_rem, in_hue_word[NUM_W-1]};
      hue_take    = hue_trial >= {1'b0, in_hue_div};
      hue_rem_in  = hue_take ? CHAN_W'(hue_trial - {1'b0, in_hue_div})
                             : hue_trial[CHAN_W-1:0];
      hue_word_in = {in_hue_word[NUM_W-2:0], hue_take};

      sat_trial   = {in_sat_rem, in_sat_word[NUM_W-1]};
      sat_take    = sat_trial >= {1'b0, in_sat_div};
      sat_rem_in  = sat_take ? CHAN_W'(sat_trial - {1'b0, in_sat_div})
                             : sat_trial[CHAN_W-1:0];
      sat_word_in = {in_sat_word[NUM_W-2:0], sat_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         point_ff    <= in_point;
         grey_ff     <= in_grey;
         hue_word_ff <= hue_word_in;
         hue_rem_ff  <= hue_rem_in;
         hue_div_ff  <= in_hue_div;
         sat_word_ff <= sat_word_in;
         sat_rem_ff  <= sat_rem_in;
         sat_div_ff  <= in_sat_div;
      end
   end

   assign out_valid    = valid_ff;
   assign out_point    = point_ff;
   assign out_grey     = grey_ff;
   assign out_hue_word = hue_word_ff;
   assign out_hue_rem  = hue_rem_ff;
   assign out_hue_div  = hue_div_ff;
   assign out_sat_word = sat_word_ff;
   assign out_sat_rem  = sat_rem_ff;
   assign out_sat_div  = sat_div_ff;

endmodule

@@ design/rhwpf_window.sv @@
// ----------------------------------------------------------------------------
// rhwpf_window
// Window test on hue, saturation and brightness, and the result register.
// ----------------------------------------------------------------------------
module rhwpf_window import rhwpf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int NUM_W     = HUE_NUM_W + FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  window_cfg_type      cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  point_type           in_point,
   input  logic                in_grey,
   input  logic [NUM_W-1:0]    in_hue_quo,
   input  logic [NUM_W-1:0]    in_sat_quo,
   input  logic [CHAN_W-1:0]   in_bright,
   output logic                out_valid,
   input  logic                out_ready,
   output point_type           out_point,
   output logic [HUE_Q_W-1:0]  out_hue_q6,
   output logic [SAT_Q_W-1:0]  out_sat_q6,
   output logic [CHAN_W-1:0]   out_bright
);

   logic               valid_ff, valid_in;
   point_type          point_ff;
   logic [HUE_Q_W-1:0] hue_ff;
   logic [SAT_Q_W-1:0] sat_ff;
   logic [CHAN_W-1:0]  bright_ff;

   logic [NUM_W-1:0]   hue_q, sat_q;
   logic               pass;

   assign hue_q = in_grey ? '0 : in_hue_quo;
   assign sat_q = in_grey ? '0 : in_sat_quo;

   assign pass = hue_q >= (NUM_W'(cfg.hue_min_deg) << FRAC_BITS)
              && hue_q <= (NUM_W'(cfg.hue_max_deg) << FRAC_BITS)
              && sat_q >= (NUM_W'(cfg.sat_min_pct) << FRAC_BITS)
              && sat_q <= (NUM_W'(cfg.sat_max_pct) << FRAC_BITS)
              && in_bright >= cfg.val_min
              && in_bright <= cfg.val_max;

   assign in_ready = !valid_ff || out_ready;

   // drop rejected points on acceptance
   always_comb begin
      if (in_ready) begin
         valid_in = in_valid && pass;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         point_ff  <= in_point;
         hue_ff    <= hue_q[HUE_Q_W-1:0];
         sat_ff    <= sat_q[SAT_Q_W-1:0];
         bright_ff <= in_bright;
      end
   end

   assign out_valid  = valid_ff;
   assign out_point  = point_ff;
   assign out_hue_q6 = hue_ff;
   assign out_sat_q6 = sat_ff;
   assign out_bright = bright_ff;

endmodule

@@ test/tb_rgb_hsv_window_point_filter_core.sv @@
// ----------------------------------------------------------------------------
// tb_rgb_hsv_window_point_filter_core
// Self-checking bench for the RGB/HSV window point filter. Points go in through
// a randomly idling sender and results are taken by a randomly stalling
// receiver. An integer HSV predictor with its own copy of the window registers
// works out which points survive and with what hue, saturation and brightness.
// Each result is checked field by field against the oldest prediction. Window
// settings are changed over the APB port between phases, with the pipeline
// empty. The phases cover the reset window, wide-open, inverted and all-zero
// windows, masked out-of-range writes, unmapped addresses, random windows,
// long back-pressure and full-rate streaming.
// ----------------------------------------------------------------------------
module tb_rgb_hsv_window_point_filter_core;
   import rhwpf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC           = FRAC_BITS_DEF;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF       = 150;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef struct {
      logic signed [COORD_W-1:0] x_mm;
      logic signed [COORD_W-1:0] y_mm;
      logic signed [COORD_W-1:0] z_mm;
      logic [CHAN_W-1:0]         red;
      logic [CHAN_W-1:0]         green;
      logic [CHAN_W-1:0]         blue;
      logic [HUE_Q_W-1:0]        hue_q6;
      logic [SAT_Q_W-1:0]        sat_q6;
      logic [CHAN_W-1:0]         brightness;
   } filtered_point_type;

   logic clock = 1'b0;
   logic reset;

   logic                      req_valid;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_pos_x_mm;
   logic signed [COORD_W-1:0] req_pos_y_mm;
   logic signed [COORD_W-1:0] req_pos_z_mm;
   logic [CHAN_W-1:0]         req_red;
   logic [CHAN_W-1:0]         req_green;
   logic [CHAN_W-1:0]         req_blue;

   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [COORD_W-1:0] rsp_out_x_mm;
   logic signed [COORD_W-1:0] rsp_out_y_mm;
   logic signed [COORD_W-1:0] rsp_out_z_mm;
   logic [CHAN_W-1:0]         rsp_out_red;
   logic [CHAN_W-1:0]         rsp_out_green;
   logic [CHAN_W-1:0]         rsp_out_blue;
   logic [HUE_Q_W-1:0]        rsp_hue_q6;
   logic [SAT_Q_W-1:0]        rsp_sat_q6;
   logic [CHAN_W-1:0]         rsp_brightness;

   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_W-1:0]     csr_paddr;
   logic [CSR_DATA_W-1:0]     csr_pwdata;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   window_cfg_type  win = '{HUE_MIN_RST, HUE_MAX_RST, SAT_MIN_RST, SAT_MAX_RST,
                            VAL_MIN_RST, VAL_MAX_RST};
   filtered_point_type expected_points[$];

   int errors          = 0;
   int points_sent     = 0;
   int points_checked  = 0;
   int window_settings = 1;
   int idle_cycles     = 0;
   int rsp_hold_req    = 0;
   bit req_no_idle     = 1'b0;
   bit rsp_no_idle     = 1'b0;

   rgb_hsv_window_point_filter_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pos_x_mm   (req_pos_x_mm),
      .req_pos_y_mm   (req_pos_y_mm),
      .req_pos_z_mm   (req_pos_z_mm),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_x_mm   (rsp_out_x_mm),
      .rsp_out_y_mm   (rsp_out_y_mm),
      .rsp_out_z_mm   (rsp_out_z_mm),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_hue_q6     (rsp_hue_q6),
      .rsp_sat_q6     (rsp_sat_q6),
      .rsp_brightness (rsp_brightness),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit filter_point(input point_type p, input window_cfg_type w,
                                       output filtered_point_type r);
      longint     mx, mn, d, diff, base, num, hq, sq;
      sector_type sector;
      mx = longint'(p.red);
      mn = longint'(p.red);
      if (longint'(p.green) > mx) mx = longint'(p.green);
      if (longint'(p.blue) > mx) mx = longint'(p.blue);
      if (longint'(p.green) < mn) mn = longint'(p.green);
      if (longint'(p.blue) < mn) mn = longint'(p.blue);
      hq = 0;
      sq = 0;
      if (mx != mn) begin
         d = mx - mn;
         if (mx == longint'(p.red)) sector = SECTOR_RED;
         else if (mx == longint'(p.green)) sector = SECTOR_GREEN;
         else sector = SECTOR_BLUE;
         case (sector)
            SECTOR_RED: begin
               diff = longint'(p.green) - longint'(p.blue);
               base = 0;
            end
            SECTOR_GREEN: begin
               diff = longint'(p.blue) - longint'(p.red);
               base = 120;
            end
            default: begin
               diff = longint'(p.red) - longint'(p.green);
               base = 240;
            end
         endcase
         num = 60 * diff + base * d;
         if (num < 0) num += 360 * d;
         hq = (num <<< FRAC) / d;
         sq = ((d * 100) <<< FRAC) / mx;
      end
      r.x_mm       = p.pos_x_mm;
      r.y_mm       = p.pos_y_mm;
      r.z_mm       = p.pos_z_mm;
      r.red        = p.red;
      r.green      = p.green;
      r.blue       = p.blue;
      r.hue_q6     = hq[HUE_Q_W-1:0];
      r.sat_q6     = sq[SAT_Q_W-1:0];
      r.brightness = mx[CHAN_W-1:0];
      return hq >= (longint'(w.hue_min_deg) <<< FRAC) && hq <= (longint'(w.hue_max_deg) <<< FRAC)
          && sq >= (longint'(w.sat_min_pct) <<< FRAC) && sq <= (longint'(w.sat_max_pct) <<< FRAC)
          && mx >= longint'(w.val_min) && mx <= longint'(w.val_max);
   endfunction

   function automatic point_type make_point(input int x, input int y, input int z,
                                            input int r, input int g, input int b);
      point_type p;
      p.pos_x_mm = COORD_W'(x);
      p.pos_y_mm = COORD_W'(y);
      p.pos_z_mm = COORD_W'(z);
      p.red      = CHAN_W'(r);
      p.green    = CHAN_W'(g);
      p.blue     = CHAN_W'(b);
      return p;
   endfunction

   function automatic logic [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         default: return COORD_W'($urandom());
      endcase
   endfunction

   function automatic point_type random_point();
      point_type p;
      int        top, lvl, pick;
      p.pos_x_mm = random_coord();
      p.pos_y_mm = random_coord();
      p.pos_z_mm = random_coord();
      p.red      = CHAN_W'($urandom());
      p.green    = CHAN_W'($urandom());
      p.blue     = CHAN_W'($urandom());
      case ($urandom_range(0, 9))
         4: begin
            lvl = $urandom_range(0, 255);
            p = make_point(p.pos_x_mm, p.pos_y_mm, p.pos_z_mm, lvl, lvl, lvl);
         end
         5: begin
            top  = $urandom_range(0, 255);
            lvl  = $urandom_range(0, top);
            pick = $urandom_range(0, 2);
            p.red   = CHAN_W'((pick == 2) ? lvl : top);
            p.green = CHAN_W'((pick == 1) ? lvl : top);
            p.blue  = CHAN_W'((pick == 0) ? lvl : top);
         end
         6: begin
            case ($urandom_range(0, 2))
               0: p.red = CHAN_W'($urandom_range(235, 255));
               1: p.green = CHAN_W'($urandom_range(235, 255));
               default: p.blue = CHAN_W'($urandom_range(235, 255));
            endcase
         end
         7: begin
            lvl = $urandom_range(2, 253);
            p = make_point(p.pos_x_mm, p.pos_y_mm, p.pos_z_mm, lvl,
                           lvl - 1 + $urandom_range(0, 2), lvl - 1 + $urandom_range(0, 2));
         end
         8, 9: begin
            p.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
            p.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
            p.blue  = $urandom_range(0, 1) ? 8'hff : CHAN_W'($urandom_range(0, 255));
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic send_point(input point_type p);
      filtered_point_type result;
      int unsigned        gap;
      gap = req_no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pos_x_mm <= p.pos_x_mm;
      req_pos_y_mm <= p.pos_y_mm;
      req_pos_z_mm <= p.pos_z_mm;
      req_red      <= p.red;
      req_green    <= p.green;
      req_blue     <= p.blue;
      do @(posedge clock); while (!req_ready);
      points_sent++;
      if (filter_point(p, win, result)) expected_points.insert(expected_points.size(), result);
   endtask

   task automatic send_random_points(input int count);
      repeat (count) send_point(random_point());
   endtask

   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window_reg(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_HUE_MIN: win.hue_min_deg = value[HUE_CFG_W-1:0];
         REG_HUE_MAX: win.hue_max_deg = value[HUE_CFG_W-1:0];
         REG_SAT_MIN: win.sat_min_pct = value[CHAN_W-1:0];
         REG_SAT_MAX: win.sat_max_pct = value[CHAN_W-1:0];
         REG_VAL_MIN: win.val_min = value[CHAN_W-1:0];
         REG_VAL_MAX: win.val_max = value[CHAN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_window(input logic [CSR_DATA_W-1:0] hue_lo, hue_hi,
                               input logic [CSR_DATA_W-1:0] sat_lo, sat_hi,
                               input logic [CSR_DATA_W-1:0] val_lo, val_hi);
      settle_pipeline();
      write_window_reg(REG_HUE_MIN, hue_lo);
      write_window_reg(REG_HUE_MAX, hue_hi);
      write_window_reg(REG_SAT_MIN, sat_lo);
      write_window_reg(REG_SAT_MAX, sat_hi);
      write_window_reg(REG_VAL_MIN, val_lo);
      write_window_reg(REG_VAL_MAX, val_hi);
      window_settings++;
   endtask

   task automatic test_reset_window();
      send_point(make_point(32767, -32768, 0, 255, 0, 0));
      send_point(make_point(-32768, 32767, -1, 255, 255, 0));
      send_point(make_point(0, -1, 32767, 255, 255, 255));
      send_point(make_point(-1, 0, -32768, 0, 0, 0));
      send_point(make_point(100, -100, 7, 254, 255, 225));
      send_point(make_point(-7, 21845, -21846, 252, 255, 195));
      send_point(make_point(1, 2, 3, 255, 0, 1));
      send_point(make_point(-2, -3, -4, 0, 255, 0));
      send_point(make_point(4660, -4660, 0, 0, 0, 255));
      send_point(make_point(0, 0, 0, 0, 255, 255));
      send_point(make_point(12345, -12345, 1, 235, 100, 0));
      send_point(make_point(-12345, 12345, -1, 234, 100, 0));
      send_point(make_point(300, 400, 500, 255, 128, 64));
      send_point(make_point(-300, -400, -500, 1, 0, 0));
      send_point(make_point(16384, -16384, 8192, 255, 254, 254));
      send_point(make_point(-8192, 8191, -16385, 128, 128, 128));
   endtask

   task automatic test_open_window();
      apply_window(0, 360, 0, 255, 0, 255);
      send_point(make_point(32767, 32767, 32767, 255, 0, 1));
      send_point(make_point(-32768, -32768, -32768, 0, 255, 255));
      send_point(make_point(5, -5, 5, 0, 0, 255));
      send_point(make_point(-5, 5, -5, 0, 0, 0));
      send_point(make_point(9, 9, -9, 1, 0, 0));
      send_point(make_point(-9, -9, 9, 255, 0, 255));
      send_point(make_point(0, 1, -1, 0, 1, 0));
      send_random_points(60);
   endtask

   task automatic test_window_extremes();
      // inverted windows let nothing through
      apply_window(300, 100, 0, 255, 0, 255);
      send_random_points(25);
      apply_window(0, 360, 80, 20, 200, 100);
      send_random_points(25);
      // all-zero window: only black survives
      apply_window(0, 0, 0, 0, 0, 0);
      repeat (3) send_point(make_point($urandom(), $urandom(), $urandom(), 0, 0, 0));
      send_random_points(25);
      // upper bits beyond each register width are dropped
      apply_window(32'hffff_fe00, 32'h0000_01ff, 32'hffff_ff00, 32'h0000_01ff,
                   32'habcd_1200, 32'hffff_ffff);
      send_random_points(25);
      // unmapped registers leave the window alone
      settle_pipeline();
      write_window_reg(REG_SPARE_LO, 32'h0000_0000);
      write_window_reg(REG_SPARE_HI, 32'h0000_0000);
      send_random_points(25);
   endtask

   task automatic test_random_windows();
      int unsigned hue_lo, sat_lo, val_lo;
      repeat (4) begin
         hue_lo = $urandom_range(0, 300);
         sat_lo = $urandom_range(0, 60);
         val_lo = $urandom_range(0, 200);
         apply_window(hue_lo, hue_lo + $urandom_range(30, 211), sat_lo,
                      $urandom_range(sat_lo, 255), val_lo, $urandom_range(val_lo, 255));
         send_random_points(70);
      end
   endtask

   task automatic test_backpressure();
      apply_window(0, 360, 0, 255, 0, 255);
      rsp_hold_req = HOLD_OFF;
      req_no_idle  = 1'b1;
      send_random_points(80);
      req_no_idle  = 1'b0;
      settle_pipeline();
   endtask

   task automatic test_full_rate();
      req_no_idle = 1'b1;
      rsp_no_idle = 1'b1;
      send_random_points(100);
      req_no_idle = 1'b0;
      rsp_no_idle = 1'b0;
   endtask

   initial begin
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_pos_x_mm <= '0;
      req_pos_y_mm <= '0;
      req_pos_z_mm <= '0;
      req_red      <= '0;
      req_green    <= '0;
      req_blue     <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_window();
      test_open_window();
      test_window_extremes();
      test_random_windows();
      test_backpressure();
      test_full_rate();
      settle_pipeline();
      $display("Sent %0d points through %0d window settings; %0d passed and were checked.",
               points_sent, window_settings, points_checked);
      $display("Covered grey, tied, wrapped and boundary hues, masked writes and stalls.");
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : receiver
      int unsigned stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_no_idle ? 0 : $urandom_range(0, 3);
         if (rsp_hold_req > 0) begin
            stall = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid && rsp_hold_req == 0);
      end
   end

   always @(posedge clock) begin : check_results
      filtered_point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            $error("result with no point expected: hue_q6 %0d, brightness %0d",
                   rsp_hue_q6, rsp_brightness);
            errors++;
         end else begin
            want = expected_points.pop_front();
            points_checked++;
            if (rsp_out_x_mm !== want.x_mm) begin
               $error("out_x_mm: expected %0d, got %0d", want.x_mm, rsp_out_x_mm);
               errors++;
            end
            if (rsp_out_y_mm !== want.y_mm) begin
               $error("out_y_mm: expected %0d, got %0d", want.y_mm, rsp_out_y_mm);
               errors++;
            end
            if (rsp_out_z_mm !== want.z_mm) begin
               $error("out_z_mm: expected %0d, got %0d", want.z_mm, rsp_out_z_mm);
               errors++;
            end
            if (rsp_out_red !== want.red) begin
               $error("out_red: expected %0d, got %0d", want.red, rsp_out_red);
               errors++;
            end
            if (rsp_out_green !== want.green) begin
               $error("out_green: expected %0d, got %0d", want.green, rsp_out_green);
               errors++;
            end
            if (rsp_out_blue !== want.blue) begin
               $error("out_blue: expected %0d, got %0d", want.blue, rsp_out_blue);
               errors++;
            end
            if (rsp_hue_q6 !== want.hue_q6) begin
               $error("hue_q6: expected %0d, got %0d", want.hue_q6, rsp_hue_q6);
               errors++;
            end
            if (rsp_sat_q6 !== want.sat_q6) begin
               $error("sat_q6: expected %0d, got %0d", want.sat_q6, rsp_sat_q6);
               errors++;
            end
            if (rsp_brightness !== want.brightness) begin
               $error("brightness: expected %0d, got %0d", want.brightness, rsp_brightness);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("No transaction for %0d cycles, %0d results outstanding.",
                     WATCHDOG_LIMIT, expected_points.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

endmodule

@@ rgb_hsv_window_point_filter_core.f @@
design/rhwpf_pkg.sv
design/rhwpf_front.sv
design/rhwpf_div_stage.sv
design/rhwpf_window.sv
design/rgb_hsv_window_point_filter_core.sv
test/tb_rgb_hsv_window_point_filter_core.sv
